// ===== hw/rtl/dtq_pkg.sv =====
// dtq_pkg: shared types, codes and widths for the deadline timer queue
// used by dtq_cell and deadline_timer_queue; no dependencies
`default_nettype none

package dtq_pkg;

  // fixed field widths
  localparam int OPCODE_W   = 3;
  localparam int NOW_W      = 40;
  localparam int DELAY_W    = 31;
  localparam int DEADLINE_W = 41;
  localparam int STATUS_W   = 3;
  localparam int LATE_W     = 31;
  localparam int WAIT_W     = 41;
  localparam int OCC_W      = 5;

  // parameter defaults
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_OWNER_BITS  = 8;
  localparam int DEF_TAG_BITS    = 16;

  // saturation limit of the lateness field
  localparam logic [LATE_W-1:0] LATE_MAX = {LATE_W{1'b1}};

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT          = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CHECK           = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CANCEL_PERIODIC = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_CANCEL_OWNER    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CANCEL_TAG      = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WAITING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // entry kinds
  localparam logic KIND_PERIODIC = 1'b0;
  localparam logic KIND_ALARM    = 1'b1;

  // command broadcast from the sequencer to every cell
  typedef struct packed {
    logic                ins;
    logic                pop;
    logic                cancel;
    logic [OPCODE_W-1:0] opcode;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtq_cell.sv =====
// dtq_cell: one slot of the sorted deadline chain
// depends on dtq_pkg; neighbours exchange entries for insert and pop
`default_nettype none

module dtq_cell #(
  parameter int OWNER_BITS = dtq_pkg::DEF_OWNER_BITS,
  parameter int TAG_BITS   = dtq_pkg::DEF_TAG_BITS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire dtq_pkg::cell_cmd_t          cmd,
  // broadcast new entry and cancel keys
  input  wire [dtq_pkg::DEADLINE_W-1:0]    new_deadline,
  input  wire [OWNER_BITS-1:0]             new_owner,
  input  wire                              new_kind,
  input  wire [TAG_BITS-1:0]               new_tag,
  // left neighbour (towards the head)
  input  wire                              left_take,
  input  wire                              left_valid,
  input  wire                              left_live,
  input  wire [dtq_pkg::DEADLINE_W-1:0]    left_deadline,
  input  wire [OWNER_BITS-1:0]             left_owner,
  input  wire                              left_kind,
  input  wire [TAG_BITS-1:0]               left_tag,
  // right neighbour (towards the tail)
  input  wire                              right_valid,
  input  wire                              right_live,
  input  wire [dtq_pkg::DEADLINE_W-1:0]    right_deadline,
  input  wire [OWNER_BITS-1:0]             right_owner,
  input  wire                              right_kind,
  input  wire [TAG_BITS-1:0]               right_tag,
  // own contents
  output logic                             take,
  output logic                             valid,
  output logic                             live,
  output logic [dtq_pkg::DEADLINE_W-1:0]   deadline,
  output logic [OWNER_BITS-1:0]            owner,
  output logic                             kind,
  output logic [TAG_BITS-1:0]              tag
);

  logic                           valid_r, valid_nxt;
  logic                           live_r, live_nxt;
  logic [dtq_pkg::DEADLINE_W-1:0] deadline_r, deadline_nxt;
  logic [OWNER_BITS-1:0]          owner_r, owner_nxt;
  logic                           kind_r, kind_nxt;
  logic [TAG_BITS-1:0]            tag_r, tag_nxt;
  logic                           hit;

  // slot lies at or behind the insert point
  assign take = !valid_r || (deadline_r > new_deadline);

  // cancel match
  always_comb begin
    case (cmd.opcode)
      dtq_pkg::OP_CANCEL_PERIODIC: hit = (owner_r == new_owner) &&
                                         (kind_r == dtq_pkg::KIND_PERIODIC);
      dtq_pkg::OP_CANCEL_OWNER:    hit = (owner_r == new_owner);
      dtq_pkg::OP_CANCEL_TAG:      hit = (kind_r == dtq_pkg::KIND_ALARM) &&
                                         (tag_r == new_tag);
      default:                     hit = 1'b0;
    endcase
  end

  // next contents
  always_comb begin
    valid_nxt    = valid_r;
    live_nxt     = live_r;
    deadline_nxt = deadline_r;
    owner_nxt    = owner_r;
    kind_nxt     = kind_r;
    tag_nxt      = tag_r;
    if (cmd.ins && take) begin
      if (left_take) begin
        valid_nxt    = left_valid;
        live_nxt     = left_live;
        deadline_nxt = left_deadline;
        owner_nxt    = left_owner;
        kind_nxt     = left_kind;
        tag_nxt      = left_tag;
      end else begin
        valid_nxt    = 1'b1;
        live_nxt     = 1'b1;
        deadline_nxt = new_deadline;
        owner_nxt    = new_owner;
        kind_nxt     = new_kind;
        tag_nxt      = new_tag;
      end
    end else if (cmd.pop) begin
      valid_nxt    = right_valid;
      live_nxt     = right_live;
      deadline_nxt = right_deadline;
      owner_nxt    = right_owner;
      kind_nxt     = right_kind;
      tag_nxt      = right_tag;
    end else if (cmd.cancel && hit) begin
      live_nxt = 1'b0;
    end
  end

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      live_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      live_r  <= live_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    owner_r    <= owner_nxt;
    kind_r     <= kind_nxt;
    tag_r      <= tag_nxt;
  end

  assign valid    = valid_r;
  assign live     = live_r;
  assign deadline = deadline_r;
  assign owner    = owner_r;
  assign kind     = kind_r;
  assign tag      = tag_r;

endmodule

`default_nettype wire

// ===== hw/rtl/deadline_timer_queue.sv =====
// deadline_timer_queue: top level, request sequencer and the chain of cells
// depends on dtq_pkg and dtq_cell
`default_nettype none

// Deadline queue held in time order in a row of QUEUE_DEPTH cells, slot 0 at
// the head. A request is taken at a rising edge with start high and busy low.
// Insert files now_us + delay_us behind every entry with an equal or earlier
// deadline; check pops dead entries off the head, then pops the head if it
// is due or reports the wait; the three cancels clear live bits in place.
// Every request gives exactly one result, shown on the out_ ports for one
// cycle with out_valid high; the receiver cannot hold it off.
// Insert, cancel and check each run through the execute state after the
// accepting edge, and the result is registered as the sequencer goes idle;
// a check stays in the execute state while it pops dead entries off the
// head, one cell shift per cycle. busy drops as the result is shown, so a
// new request can be taken in that cycle; none is taken while busy.
// The shift of the whole row and the head compare happen in each execute
// cycle, after the deadline sum is registered at acceptance.
// Reset (rst_n low, synchronous) empties the queue and clears busy and
// out_valid; cell payload is not cleared.
module deadline_timer_queue #(
  parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH,
  parameter int OWNER_BITS  = dtq_pkg::DEF_OWNER_BITS,
  parameter int TAG_BITS    = dtq_pkg::DEF_TAG_BITS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [dtq_pkg::OPCODE_W-1:0]      in_opcode,
  input  wire [dtq_pkg::NOW_W-1:0]         in_now_us,
  input  wire [dtq_pkg::DELAY_W-1:0]       in_delay_us,
  input  wire [OWNER_BITS-1:0]             in_owner_id,
  input  wire                              in_entry_kind,
  input  wire [TAG_BITS-1:0]               in_alarm_tag,
  output logic                             out_valid,
  output logic [dtq_pkg::STATUS_W-1:0]     out_status,
  output logic [OWNER_BITS-1:0]            out_expired_owner,
  output logic                             out_expired_kind,
  output logic [TAG_BITS-1:0]              out_expired_tag,
  output logic [dtq_pkg::LATE_W-1:0]       out_lateness_us,
  output logic [dtq_pkg::WAIT_W-1:0]       out_wait_us,
  output logic [dtq_pkg::OCC_W-1:0]        out_occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // sequencer states
  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // request registers
  logic [dtq_pkg::OPCODE_W-1:0]   op_r;
  logic [dtq_pkg::NOW_W-1:0]      now_r;
  logic [dtq_pkg::DEADLINE_W-1:0] dl_r;
  logic [OWNER_BITS-1:0]          owner_r;
  logic                           kind_r;
  logic [TAG_BITS-1:0]            tag_r;

  // result registers
  logic                           out_valid_r, out_valid_nxt;
  logic [dtq_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [OWNER_BITS-1:0]          e_owner_r, e_owner_nxt;
  logic                           e_kind_r, e_kind_nxt;
  logic [TAG_BITS-1:0]            e_tag_r, e_tag_nxt;
  logic [dtq_pkg::LATE_W-1:0]     late_r, late_nxt;
  logic [dtq_pkg::WAIT_W-1:0]     wait_r, wait_nxt;
  logic [dtq_pkg::OCC_W-1:0]      occ_r;
  logic [CNT_W+dtq_pkg::OCC_W-1:0] occ_ext;

  dtq_pkg::cell_cmd_t cmd;

  // chain signals
  logic [QUEUE_DEPTH-1:0]         c_take, c_valid, c_live, c_kind;
  logic [dtq_pkg::DEADLINE_W-1:0] c_deadline [QUEUE_DEPTH];
  logic [OWNER_BITS-1:0]          c_owner [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]            c_tag [QUEUE_DEPTH];

  // head evaluation
  logic                           accept;
  logic                           head_dead;
  logic                           head_due;
  logic [dtq_pkg::DEADLINE_W-1:0] now_ext;
  logic [dtq_pkg::DEADLINE_W-1:0] late_diff;
  logic [dtq_pkg::DEADLINE_W-1:0] head_wait;

  assign accept    = start && (state_r == STATE_IDLE);
  assign busy      = (state_r == STATE_EXEC);
  assign head_dead = c_valid[0] && !c_live[0];
  assign now_ext   = {1'b0, now_r};
  assign head_due  = (now_ext >= c_deadline[0]);
  assign late_diff = now_ext - c_deadline[0];
  assign head_wait = c_deadline[0] - now_ext;

  // row of cells, each wired to its neighbours, the ends tied off
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                           l_take, l_valid, l_live, l_kind;
    logic [dtq_pkg::DEADLINE_W-1:0] l_deadline;
    logic [OWNER_BITS-1:0]          l_owner;
    logic [TAG_BITS-1:0]            l_tag;
    logic                           r_valid, r_live, r_kind;
    logic [dtq_pkg::DEADLINE_W-1:0] r_deadline;
    logic [OWNER_BITS-1:0]          r_owner;
    logic [TAG_BITS-1:0]            r_tag;

    if (i == 0) begin : g_head
      assign l_take     = 1'b0;
      assign l_valid    = 1'b0;
      assign l_live     = 1'b0;
      assign l_kind     = 1'b0;
      assign l_deadline = '0;
      assign l_owner    = '0;
      assign l_tag      = '0;
    end else begin : g_left
      assign l_take     = c_take[i-1];
      assign l_valid    = c_valid[i-1];
      assign l_live     = c_live[i-1];
      assign l_kind     = c_kind[i-1];
      assign l_deadline = c_deadline[i-1];
      assign l_owner    = c_owner[i-1];
      assign l_tag      = c_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid    = 1'b0;
      assign r_live     = 1'b0;
      assign r_kind     = 1'b0;
      assign r_deadline = '0;
      assign r_owner    = '0;
      assign r_tag      = '0;
    end else begin : g_right
      assign r_valid    = c_valid[i+1];
      assign r_live     = c_live[i+1];
      assign r_kind     = c_kind[i+1];
      assign r_deadline = c_deadline[i+1];
      assign r_owner    = c_owner[i+1];
      assign r_tag      = c_tag[i+1];
    end

    dtq_cell #(
      .OWNER_BITS (OWNER_BITS),
      .TAG_BITS   (TAG_BITS)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd),
      .new_deadline   (dl_r),
      .new_owner      (owner_r),
      .new_kind       (kind_r),
      .new_tag        (tag_r),
      .left_take      (l_take),
      .left_valid     (l_valid),
      .left_live      (l_live),
      .left_deadline  (l_deadline),
      .left_owner     (l_owner),
      .left_kind      (l_kind),
      .left_tag       (l_tag),
      .right_valid    (r_valid),
      .right_live     (r_live),
      .right_deadline (r_deadline),
      .right_owner    (r_owner),
      .right_kind     (r_kind),
      .right_tag      (r_tag),
      .take           (c_take[i]),
      .valid          (c_valid[i]),
      .live           (c_live[i]),
      .deadline       (c_deadline[i]),
      .owner          (c_owner[i]),
      .kind           (c_kind[i]),
      .tag            (c_tag[i])
    );
  end

  // sequencer: each request runs in the execute state, repeated while purging
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.opcode    = op_r;
    out_valid_nxt = 1'b0;
    status_nxt    = dtq_pkg::ST_DONE;
    e_owner_nxt   = '0;
    e_kind_nxt    = 1'b0;
    e_tag_nxt     = '0;
    late_nxt      = '0;
    wait_nxt      = '0;
    if (state_r == STATE_IDLE) begin
      if (start) begin
        state_nxt = STATE_EXEC;
      end
    end else begin
      state_nxt     = STATE_IDLE;
      out_valid_nxt = 1'b1;
      case (op_r)
        dtq_pkg::OP_INSERT: begin
          if (cnt_r == CNT_FULL) begin
            status_nxt = dtq_pkg::ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            cnt_nxt = cnt_r + CNT_ONE;
          end
        end
        dtq_pkg::OP_CHECK: begin
          if (head_dead) begin
            // drop a dead head and look again next cycle
            cmd.pop       = 1'b1;
            cnt_nxt       = cnt_r - CNT_ONE;
            state_nxt     = STATE_EXEC;
            out_valid_nxt = 1'b0;
          end else if (!c_valid[0]) begin
            status_nxt = dtq_pkg::ST_EMPTY;
          end else if (head_due) begin
            cmd.pop     = 1'b1;
            cnt_nxt     = cnt_r - CNT_ONE;
            status_nxt  = dtq_pkg::ST_EXPIRED;
            e_owner_nxt = c_owner[0];
            e_kind_nxt  = c_kind[0];
            e_tag_nxt   = c_tag[0];
            late_nxt    = (|late_diff[dtq_pkg::DEADLINE_W-1:dtq_pkg::LATE_W]) ?
                          dtq_pkg::LATE_MAX : late_diff[dtq_pkg::LATE_W-1:0];
          end else begin
            status_nxt = dtq_pkg::ST_WAITING;
            wait_nxt   = head_wait;
          end
        end
        dtq_pkg::OP_CANCEL_PERIODIC,
        dtq_pkg::OP_CANCEL_OWNER,
        dtq_pkg::OP_CANCEL_TAG: begin
          cmd.cancel = 1'b1;
        end
        default: begin
          status_nxt = dtq_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign occ_ext = {{dtq_pkg::OCC_W{1'b0}}, cnt_nxt};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture, deadline sum formed here
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      now_r   <= in_now_us;
      dl_r    <= dtq_pkg::DEADLINE_W'(in_now_us) + dtq_pkg::DEADLINE_W'(in_delay_us);
      owner_r <= in_owner_id;
      kind_r  <= in_entry_kind;
      tag_r   <= in_alarm_tag;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    e_owner_r <= e_owner_nxt;
    e_kind_r  <= e_kind_nxt;
    e_tag_r   <= e_tag_nxt;
    late_r    <= late_nxt;
    wait_r    <= wait_nxt;
    occ_r     <= occ_ext[dtq_pkg::OCC_W-1:0];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_expired_owner = e_owner_r;
  assign out_expired_kind  = e_kind_r;
  assign out_expired_tag   = e_tag_r;
  assign out_lateness_us   = late_r;
  assign out_wait_us       = wait_r;
  assign out_occupancy     = occ_r;

`ifndef SYNTH
  // valid cells always match the entry count
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(c_valid) == int'(cnt_r))
    else $error("entry count differs from valid cells");

  // valid cells form a contiguous run from the head
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid & (c_valid + QUEUE_DEPTH'(1))) == '0)
    else $error("hole in the valid run of the chain");

  // a result follows an execute cycle and never one that keeps purging
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == STATE_EXEC) && (state_r == STATE_IDLE))
    else $error("result without a finished execute cycle");

  // a rejected insert only happens with every cell in use
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == dtq_pkg::ST_FULL)) |-> (&c_valid))
    else $error("insert rejected while a cell was free");
`endif

endmodule

`default_nettype wire
